>>> rtl/fcvm_pkg.sv
`default_nettype none
package fcvm_pkg;

  localparam int CORDIC_STAGES = 14;
  localparam int ATAN_COUNT = 20;
  localparam int NSTG = (CORDIC_STAGES < ATAN_COUNT) ? CORDIC_STAGES : ATAN_COUNT;
  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);

  localparam logic signed [33:0] CORDIC_K = 34'sd652032874;
  localparam logic signed [33:0] PI_Q29 = 34'sd1686629713;
  localparam logic signed [33:0] HALF_PI_Q29 = 34'sd843314857;
  localparam logic signed [15:0] ANGLE_MAX = 16'sd25736;

  // one angle after range reduction, as the cordic takes it
  typedef struct packed {
    logic signed [33:0] z;
    logic neg;
  } ang_t;

  // request passed from the front to the back
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    ang_t pitch;
    ang_t yaw;
  } req_t;

  function automatic logic signed [33:0] atan_q29(input int i);
    logic signed [33:0] r;
    begin
      case (i)
        0: r = 34'sd421657428;
        1: r = 34'sd248918915;
        2: r = 34'sd131521918;
        3: r = 34'sd66762579;
        4: r = 34'sd33510843;
        5: r = 34'sd16771758;
        6: r = 34'sd8387925;
        7: r = 34'sd4194219;
        8: r = 34'sd2097141;
        9: r = 34'sd1048575;
        10: r = 34'sd524288;
        11: r = 34'sd262144;
        12: r = 34'sd131072;
        13: r = 34'sd65536;
        14: r = 34'sd32768;
        15: r = 34'sd16384;
        16: r = 34'sd8192;
        17: r = 34'sd4096;
        18: r = 34'sd2048;
        19: r = 34'sd1024;
        default: r = 34'sd0;
      endcase
      return r;
    end
  endfunction

  // clamp an angle and fold it into plus or minus pi/2
  function automatic ang_t reduce(input logic signed [15:0] a);
    logic signed [15:0] c;
    logic signed [33:0] z;
    ang_t r;
    begin
      c = a;
      if (a > ANGLE_MAX) c = ANGLE_MAX;
      if (a < -ANGLE_MAX) c = -ANGLE_MAX;
      z = {{2{c[15]}}, c, 16'd0};
      r.neg = 1'b0;
      r.z = z;
      if (z > HALF_PI_Q29) begin
        r.z = z - PI_Q29;
        r.neg = 1'b1;
      end else if (z < -HALF_PI_Q29) begin
        r.z = z + PI_Q29;
        r.neg = 1'b1;
      end
      return r;
    end
  endfunction

  // round a q30 value to q14 and clamp to plus or minus one
  function automatic logic signed [15:0] to_q14(input logic signed [33:0] v, input logic neg);
    logic signed [34:0] n;
    logic signed [34:0] s;
    logic signed [15:0] r;
    begin
      n = neg ? -{v[33], v} : {v[33], v};
      s = (n + 35'sd32768) >>> 16;
      if (s > 35'sd16384) r = 16'sd16384;
      else if (s < -35'sd16384) r = -16'sd16384;
      else r = s[15:0];
      return r;
    end
  endfunction

endpackage
`default_nettype wire

>>> rtl/fcvm_front.sv
`default_nettype none
module fcvm_front (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic signed [31:0] in_pos_z,
  input  wire logic signed [15:0] in_pitch_angle,
  input  wire logic signed [15:0] in_yaw_angle,
  output fcvm_pkg::req_t q_data,
  output logic q_valid,
  input  wire logic q_pop
);
  import fcvm_pkg::*;

  req_t mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QAW:0] cnt_r, cnt_nxt;
  logic push;
  req_t req;

  // classify: clamp and fold both angles
  always_comb begin
    req.px = in_pos_x;
    req.py = in_pos_y;
    req.pz = in_pos_z;
    req.pitch = reduce(in_pitch_angle);
    req.yaw = reduce(in_yaw_angle);
  end

  assign in_stall = (cnt_r == (QAW+1)'(QDEPTH));
  assign push = in_valid && !in_stall;
  assign q_valid = (cnt_r != '0);
  assign q_data = mem_r[rp_r];

  // queue pointers
  always_comb begin
    wp_nxt = push ? wp_r + 1'b1 : wp_r;
    rp_nxt = q_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (QAW+1)'(push) - (QAW+1)'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= req;
  end
endmodule
`default_nettype wire

>>> rtl/fcvm_cordic.sv
`default_nettype none
module fcvm_cordic (
  input  wire logic clk,
  input  wire logic en,
  input  wire fcvm_pkg::ang_t a_in,
  output logic signed [15:0] sin_q14,
  output logic signed [15:0] cos_q14
);
  import fcvm_pkg::*;

  logic signed [33:0] x_r [NSTG+1];
  logic signed [33:0] y_r [NSTG+1];
  logic signed [33:0] z_r [NSTG+1];
  logic neg_r [NSTG+1];

  // stage zero loads the start vector
  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= CORDIC_K;
      y_r[0] <= '0;
      z_r[0] <= a_in.z;
      neg_r[0] <= a_in.neg;
    end
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < NSTG; i++) begin : g_stg
    always_ff @(posedge clk) begin
      if (en) begin
        if (z_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_q29(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_q29(i);
        end
        neg_r[i+1] <= neg_r[i];
      end
    end
  end

  // output rounding register
  always_ff @(posedge clk) begin
    if (en) begin
      cos_q14 <= to_q14(x_r[NSTG], neg_r[NSTG]);
      sin_q14 <= to_q14(y_r[NSTG], neg_r[NSTG]);
    end
  end
endmodule
`default_nettype wire

>>> rtl/fcvm_back.sv
`default_nettype none
module fcvm_back (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire fcvm_pkg::req_t q_data,
  input  wire logic q_valid,
  output logic q_pop,
  output logic out_valid,
  input  wire logic out_stall,
  output logic signed [15:0] out_right_x,
  output logic signed [15:0] out_right_z,
  output logic signed [15:0] out_up_x,
  output logic signed [15:0] out_up_y,
  output logic signed [15:0] out_up_z,
  output logic signed [15:0] out_fwd_x,
  output logic signed [15:0] out_fwd_y,
  output logic signed [15:0] out_fwd_z,
  output logic signed [31:0] out_trans_x,
  output logic signed [31:0] out_trans_y,
  output logic signed [31:0] out_trans_z
);
  import fcvm_pkg::*;

  // cordic is nstg+2 deep, then axis, product, sum, output stages
  localparam int CD = NSTG + 2;
  localparam int DEP = CD + 4;

  logic en;
  logic [DEP-1:0] v_r;
  logic signed [31:0] px_r [CD], py_r [CD], pz_r [CD];
  logic signed [15:0] sp, cp, sy, cy;

  // whole pipeline advances unless the output is held
  assign en = !(out_valid && out_stall);
  assign q_pop = q_valid && en;
  assign out_valid = v_r[DEP-1];

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (en) v_r <= {v_r[DEP-2:0], q_valid};
  end

  fcvm_cordic u_pitch (.clk, .en, .a_in(q_data.pitch), .sin_q14(sp), .cos_q14(cp));
  fcvm_cordic u_yaw (.clk, .en, .a_in(q_data.yaw), .sin_q14(sy), .cos_q14(cy));

  // position delay line beside the cordic
  always_ff @(posedge clk) begin
    if (en) begin
      px_r[0] <= q_data.px;
      py_r[0] <= q_data.py;
      pz_r[0] <= q_data.pz;
      for (int i = 1; i < CD; i++) begin
        px_r[i] <= px_r[i-1];
        py_r[i] <= py_r[i-1];
        pz_r[i] <= pz_r[i-1];
      end
    end
  end

  // axis stage
  logic signed [15:0] ax_r [8];
  logic signed [31:0] apx_r, apy_r, apz_r;

  function automatic logic signed [15:0] mul14(input logic signed [15:0] a,
                                               input logic signed [15:0] b);
    logic signed [31:0] p;
    begin
      p = (a * b + 32'sd8192) >>> 14;
      return p[15:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r[0] <= cy;
      ax_r[1] <= -sy;
      ax_r[2] <= mul14(sy, sp);
      ax_r[3] <= cp;
      ax_r[4] <= mul14(cy, sp);
      ax_r[5] <= mul14(sy, cp);
      ax_r[6] <= -sp;
      ax_r[7] <= mul14(cp, cy);
      apx_r <= px_r[CD-1];
      apy_r <= py_r[CD-1];
      apz_r <= pz_r[CD-1];
    end
  end

  // product stage
  logic signed [15:0] bx_r [8];
  logic signed [47:0] pr_r [8];
  always_ff @(posedge clk) begin
    if (en) begin
      bx_r <= ax_r;
      pr_r[0] <= ax_r[0] * apx_r;
      pr_r[1] <= ax_r[1] * apz_r;
      pr_r[2] <= ax_r[2] * apx_r;
      pr_r[3] <= ax_r[3] * apy_r;
      pr_r[4] <= ax_r[4] * apz_r;
      pr_r[5] <= ax_r[5] * apx_r;
      pr_r[6] <= ax_r[6] * apy_r;
      pr_r[7] <= ax_r[7] * apz_r;
    end
  end

  // sum stage
  logic signed [15:0] cx_r [8];
  logic signed [49:0] sm_r [3];
  always_ff @(posedge clk) begin
    if (en) begin
      cx_r <= bx_r;
      sm_r[0] <= -(50'(pr_r[0]) + 50'(pr_r[1]));
      sm_r[1] <= -(50'(pr_r[2]) + 50'(pr_r[3]) + 50'(pr_r[4]));
      sm_r[2] <= -(50'(pr_r[5]) + 50'(pr_r[6]) + 50'(pr_r[7]));
    end
  end

  function automatic logic signed [31:0] sat(input logic signed [49:0] d);
    logic signed [49:0] s;
    logic signed [31:0] r;
    begin
      s = (d + 50'sd8192) >>> 14;
      if (s > 50'sd2147483647) r = 32'h7fffffff;
      else if (s < -50'sd2147483648) r = 32'h80000000;
      else r = s[31:0];
      return r;
    end
  endfunction

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      out_right_x <= cx_r[0];
      out_right_z <= cx_r[1];
      out_up_x <= cx_r[2];
      out_up_y <= cx_r[3];
      out_up_z <= cx_r[4];
      out_fwd_x <= cx_r[5];
      out_fwd_y <= cx_r[6];
      out_fwd_z <= cx_r[7];
      out_trans_x <= sat(sm_r[0]);
      out_trans_y <= sat(sm_r[1]);
      out_trans_z <= sat(sm_r[2]);
    end
  end
endmodule
`default_nettype wire

>>> rtl/fps_camera_view_matrix.sv
`default_nettype none
// First-person view matrix from a camera position and pitch/yaw angles. One
// pose is taken per clock while in_stall is low; results come out in order
// through the pipelined cordic followed by the axis, product, sum and output
// registers. A four-entry queue after the angle folding lets the input keep
// flowing while the output is stalled, until the queue is full.
module fps_camera_view_matrix (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic signed [31:0] in_pos_z,
  input  wire logic signed [15:0] in_pitch_angle,
  input  wire logic signed [15:0] in_yaw_angle,
  output logic out_valid,
  input  wire logic out_stall,
  output logic signed [15:0] out_right_x,
  output logic signed [15:0] out_right_z,
  output logic signed [15:0] out_up_x,
  output logic signed [15:0] out_up_y,
  output logic signed [15:0] out_up_z,
  output logic signed [15:0] out_fwd_x,
  output logic signed [15:0] out_fwd_y,
  output logic signed [15:0] out_fwd_z,
  output logic signed [31:0] out_trans_x,
  output logic signed [31:0] out_trans_y,
  output logic signed [31:0] out_trans_z
);
  import fcvm_pkg::*;

  req_t q_data;
  logic q_valid, q_pop;

  fcvm_front u_front (.clk, .rst_n, .in_valid, .in_stall, .in_pos_x, .in_pos_y,
    .in_pos_z, .in_pitch_angle, .in_yaw_angle, .q_data, .q_valid, .q_pop);

  fcvm_back u_back (.clk, .rst_n, .q_data, .q_valid, .q_pop, .out_valid, .out_stall,
    .out_right_x, .out_right_z, .out_up_x, .out_up_y, .out_up_z, .out_fwd_x,
    .out_fwd_y, .out_fwd_z, .out_trans_x, .out_trans_y, .out_trans_z);
endmodule
`default_nettype wire

>>> tb/sv/fps_camera_view_matrix_tb.sv
`timescale 1ns / 1ps
module fps_camera_view_matrix_tb;
  import fcvm_pkg::*;

  localparam int N_RANDOM = 930;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LATENCY = CORDIC_STAGES + 6;

  // one camera pose request
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
  } pose_t;

  // one view matrix result
  typedef struct packed {
    logic signed [15:0] rx, rz, ux, uy, uz, fx, fy, fz;
    logic signed [31:0] tx, ty, tz;
  } view_t;

  // directed row: pose plus optional typed-in result
  typedef struct packed {
    pose_t pose;
    logic has_fixed;
    view_t fixed;
  } row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [31:0] in_pos_x, in_pos_y, in_pos_z;
  logic signed [15:0] in_pitch_angle, in_yaw_angle;
  logic out_valid;
  logic out_stall;
  logic signed [15:0] out_right_x, out_right_z, out_up_x, out_up_y, out_up_z;
  logic signed [15:0] out_fwd_x, out_fwd_y, out_fwd_z;
  logic signed [31:0] out_trans_x, out_trans_y, out_trans_z;

  view_t pending_views[$];
  int mismatches;
  int idle_cycles;
  bit stim_done;
  bit quiet_stretch;

  fps_camera_view_matrix i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .in_pitch_angle(in_pitch_angle), .in_yaw_angle(in_yaw_angle),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_right_x(out_right_x), .out_right_z(out_right_z),
    .out_up_x(out_up_x), .out_up_y(out_up_y), .out_up_z(out_up_z),
    .out_fwd_x(out_fwd_x), .out_fwd_y(out_fwd_y), .out_fwd_z(out_fwd_z),
    .out_trans_x(out_trans_x), .out_trans_y(out_trans_y), .out_trans_z(out_trans_z)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // arithmetic shift right on 64 bit
  function automatic longint sra64(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // cordic sine and cosine of a q2.13 angle, both q1.14
  task automatic angle_sin_cos(input logic signed [15:0] a, output longint s,
                               output longint c);
    longint ang, z, x, y, dx, dy;
    bit flip;
    longint atans[20];
    atans = '{421657428, 248918915, 131521918, 66762579, 33510843,
              16771758, 8387925, 4194219, 2097141, 1048575,
              524288, 262144, 131072, 65536, 32768,
              16384, 8192, 4096, 2048, 1024};
    ang = clip(longint'(a), -25736, 25736);
    z = ang * 65536;
    x = 652032874;
    y = 0;
    flip = 1'b0;
    if (z > 843314857) begin
      z -= 1686629713;
      flip = 1'b1;
    end else if (z < -843314857) begin
      z += 1686629713;
      flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_STAGES && i < 20; i++) begin
      dx = sra64(y, i);
      dy = sra64(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atans[i];
      end else begin
        x += dx; y -= dy; z += atans[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = clip(sra64(x + 32768, 16), -16384, 16384);
    s = clip(sra64(y + 32768, 16), -16384, 16384);
  endtask

  function automatic longint mul_q14(longint a, longint b);
    return sra64(a * b + 8192, 14);
  endfunction

  function automatic longint neg_dot(longint ax, longint ay, longint az, pose_t p);
    longint d;
    d = -(ax * longint'(p.px) + ay * longint'(p.py) + az * longint'(p.pz));
    return clip(sra64(d + 8192, 14), -64'sd2147483648, 64'sd2147483647);
  endfunction

  // expected view matrix for a pose
  task automatic compute_view(input pose_t p, output view_t v);
    longint sp, cp, sy, cy;
    longint e[8];
    angle_sin_cos(p.pitch, sp, cp);
    angle_sin_cos(p.yaw, sy, cy);
    e[0] = cy; e[1] = -sy; e[2] = mul_q14(sy, sp); e[3] = cp;
    e[4] = mul_q14(cy, sp); e[5] = mul_q14(sy, cp); e[6] = -sp;
    e[7] = mul_q14(cp, cy);
    v.rx = 16'(e[0]); v.rz = 16'(e[1]); v.ux = 16'(e[2]); v.uy = 16'(e[3]);
    v.uz = 16'(e[4]); v.fx = 16'(e[5]); v.fy = 16'(e[6]); v.fz = 16'(e[7]);
    v.tx = 32'(neg_dot(e[0], 0, e[1], p));
    v.ty = 32'(neg_dot(e[2], e[3], e[4], p));
    v.tz = 32'(neg_dot(e[5], e[6], e[7], p));
  endtask

  // offer one request and wait until it is taken
  task automatic send_pose(input pose_t p);
    while ($urandom_range(99) < 14 && !quiet_stretch) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pos_x <= p.px; in_pos_y <= p.py; in_pos_z <= p.pz;
    in_pitch_angle <= p.pitch; in_yaw_angle <= p.yaw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_angle();
    int r;
    r = $urandom_range(99);
    if (r < 8) return 16'($urandom);
    if (r < 16)
      return 16'((r[0] ? 16'sd25736 : -16'sd25736) + $signed(16'($urandom_range(4))) - 2);
    return 16'($signed($urandom_range(51472)) - 25736);
  endfunction

  function automatic logic signed [31:0] rand_pos();
    int r;
    r = $urandom_range(99);
    if (r < 15) return 32'($urandom);
    if (r < 20) return r[0] ? 32'sh7fffffff : 32'sh80000000;
    return 32'($signed($urandom_range(2000000)) - 1000000);
  endfunction

  // stimulus
  initial begin
    row_t rows[$];
    row_t rw;
    pose_t p;
    view_t v;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_pos_x = '0; in_pos_y = '0; in_pos_z = '0;
    in_pitch_angle = '0; in_yaw_angle = '0;
    stim_done = 1'b0;
    quiet_stretch = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero angles at origin: cordic leaves a one-lsb sine residue
    rw = '0;
    rw.pose = '0;
    rw.has_fixed = 1'b1;
    rw.fixed = '{16'sd16384, -16'sd1, 16'sd0, 16'sd16384, 16'sd1, 16'sd1, -16'sd1,
                 16'sd16384, 32'sd0, 32'sd0, 32'sd0};
    rows.push_back(rw);
    rw = '0;
    // angle extremes, folding limits, beyond-pi saturation, position extremes
    for (int k = 0; k < 20; k++) begin
      rw = '0;
      case (k % 10)
        0: rw.pose.pitch = 16'sd25736;
        1: rw.pose.pitch = -16'sd25736;
        2: rw.pose.pitch = 16'sh7fff;
        3: rw.pose.pitch = 16'sh8000;
        4: rw.pose.pitch = 16'sd12868;
        5: rw.pose.pitch = -16'sd12869;
        6: rw.pose.pitch = 16'sd12869;
        7: rw.pose.pitch = 16'sd1;
        8: rw.pose.pitch = -16'sd1;
        default: rw.pose.pitch = 16'sd6434;
      endcase
      rw.pose.yaw = (k < 10) ? -rw.pose.pitch : rw.pose.pitch;
      rw.pose.px = (k % 3 == 0) ? 32'sh7fffffff : 32'sh80000000;
      rw.pose.py = (k % 2 == 0) ? 32'sh80000000 : 32'sh7fffffff;
      rw.pose.pz = (k < 10) ? 32'sh7fffffff : 32'sh00010000;
      rows.push_back(rw);
    end

    foreach (rows[i]) begin
      if (rows[i].has_fixed) v = rows[i].fixed;
      else compute_view(rows[i].pose, v);
      pending_views.push_back(v);
      send_pose(rows[i].pose);
    end

    // random poses; a quiet stretch without idling in the middle
    for (int n = 0; n < N_RANDOM; n++) begin
      quiet_stretch = (n >= 300 && n < 450);
      p.px = rand_pos(); p.py = rand_pos(); p.pz = rand_pos();
      p.pitch = rand_angle(); p.yaw = rand_angle();
      compute_view(p, v);
      pending_views.push_back(v);
      send_pose(p);
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver stall, with one long hold-off
  initial begin
    out_stall = 1'b0;
    @(posedge rst_n);
    repeat (200) @(posedge clk);
    out_stall <= 1'b1;
    repeat (150) @(posedge clk);
    forever begin
      out_stall <= (!quiet_stretch && $urandom_range(99) < 14);
      @(posedge clk);
    end
  end

  // result check
  always @(posedge clk) begin
    view_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_right_x, out_right_z, out_up_x, out_up_y, out_up_z, out_fwd_x,
              out_fwd_y, out_fwd_z, out_trans_x, out_trans_y, out_trans_z};
      if (pending_views.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_views.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h actual %h", want, got);
        end
      end
    end
  end

  // watchdog on cycles without any request moving
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    @(posedge rst_n);
    while (!(stim_done && pending_views.size() == 0) && idle_cycles < WATCHDOG_LIMIT)
      @(posedge clk);
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("fps_camera_view_matrix_tb NOT OK");
      $finish;
    end else begin
      repeat (LATENCY + 10) @(posedge clk);
      if (mismatches == 0) $display("fps_camera_view_matrix_tb OK");
      else $display("fps_camera_view_matrix_tb NOT OK");
      $finish;
    end
  end

endmodule

>>> fps_camera_view_matrix.f
rtl/fcvm_pkg.sv
rtl/fcvm_front.sv
rtl/fcvm_cordic.sv
rtl/fcvm_back.sv
rtl/fps_camera_view_matrix.sv
tb/sv/fps_camera_view_matrix_tb.sv
